// File: rtl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types, codes and fixed-point helpers for the least-squares line fit.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int MAX_POINTS_DEF = 128;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FLAT = 2'd1;
  localparam logic [1:0] ST_FEW  = 2'd2;
  localparam logic [1:0] ST_DROP = 2'd3;

  localparam logic [1:0] DIV_MEAN_X = 2'd0;
  localparam logic [1:0] DIV_MEAN_Y = 2'd1;
  localparam logic [1:0] DIV_SLOPE  = 2'd2;
  localparam logic [1:0] DIV_VAR    = 2'd3;

  localparam logic [2:0] MUL_DXDX = 3'd0;
  localparam logic [2:0] MUL_DXDY = 3'd1;
  localparam logic [2:0] MUL_BXM  = 3'd2;
  localparam logic [2:0] MUL_BX   = 3'd3;
  localparam logic [2:0] MUL_DUDU = 3'd4;
  localparam logic [2:0] MUL_DRDR = 3'd5;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [47:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] S48_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic       load;
    logic       div_go;
    logic [1:0] div_sel;
    logic       mul_go;
    logic [2:0] mul_sel;
    logic       clr_acc;
    logic       idx_clr;
    logic       idx_inc;
    logic       ld_xm;
    logic       ld_ym;
    logic       ld_lxx;
    logic       ld_lxy;
    logic       ld_b;
    logic       ld_a;
    logic       ld_fit;
    logic       ld_u;
    logic       ld_q;
    logic       ld_var;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic idx_last;
    logic lxx_zero;
    logic n_ge3;
  } stat_t;

  function automatic logic [63:0] sat_mag(input logic [63:0] m, input logic neg,
                                          input logic ovf);
    logic big;
    big = ovf || m[63];
    if (neg) return big ? S64_MIN : 64'(-m);
    return big ? S64_MAX : m;
  endfunction

  function automatic logic [63:0] sadd64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [47:0] clamp48(input logic [63:0] v);
    if (!v[63] && (v[62:47] != 16'd0)) return S48_MAX;
    if (v[63] && (v[62:47] != 16'hFFFF)) return S48_MIN;
    return v[47:0];
  endfunction

  function automatic logic [62:0] uadd63(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? {63{1'b1}} : s[62:0];
  endfunction

endpackage

// File: rtl/lsf_mul.sv
// ----------------------------------------------------------------------------
// lsf_mul
// Fixed-point product round(a*b / 2^FRAC_BITS), saturated to 64 bits, built
// from four 32x32 partial products.
// ----------------------------------------------------------------------------
module lsf_mul #(
  parameter int FRAC_BITS = lsf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        done,
  output logic [63:0] prod
);

  localparam logic [127:0] RND = (128'd1 << FRAC_BITS) >> 1;

  logic [63:0]  ma, mb, pp;
  logic         neg, run, pp_vld;
  logic [2:0]   cnt;
  logic [1:0]   pp_sh;
  logic [127:0] acc, rnd, shd;
  logic [31:0]  seg_a, seg_b;

  assign seg_a = cnt[1] ? ma[63:32] : ma[31:0];
  assign seg_b = cnt[0] ? mb[63:32] : mb[31:0];
  assign rnd   = acc + RND;
  assign shd   = rnd >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done   <= 1'b0;
      pp_vld <= 1'b0;
      cnt    <= 3'd0;
    end else begin
      done <= 1'b0;
      if (go) begin
        ma     <= op_a[63] ? 64'(-op_a) : op_a;
        mb     <= op_b[63] ? 64'(-op_b) : op_b;
        neg    <= op_a[63] ^ op_b[63];
        acc    <= 128'd0;
        cnt    <= 3'd0;
        pp_vld <= 1'b0;
        run    <= 1'b1;
      end else if (run) begin
        cnt    <= cnt + 3'd1;
        pp_vld <= !cnt[2];
        if (!cnt[2]) begin
          pp    <= 64'(seg_a * seg_b);
          pp_sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
        end
        if (pp_vld) acc <= acc + (128'(pp) << {pp_sh, 5'd0});
        if (cnt == 3'd5) begin
          prod <= lsf_pkg::sat_mag(shd[63:0], neg, |shd[127:64]);
          done <= 1'b1;
          run  <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/lsf_div.sv
// ----------------------------------------------------------------------------
// lsf_div
// Restoring divider, 128-bit numerator by 64-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module lsf_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         done,
  output logic [127:0] quo
);

  logic [63:0] d, rem, rem_sh;
  logic [6:0]  cnt;
  logic        run, ge;

  assign rem_sh = {rem[62:0], quo[127]};
  assign ge     = rem_sh >= d;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (go) begin
        quo <= num;
        d   <= den;
        rem <= 64'd0;
        cnt <= 7'd0;
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? rem_sh - d : rem_sh;
        quo <= {quo[126:0], ge};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/lsf_datapath.sv
// ----------------------------------------------------------------------------
// lsf_datapath
// Point store, running sums, fit registers and the shared multiply and
// divide units.
// ----------------------------------------------------------------------------
module lsf_datapath #(
  parameter int MAX_POINTS = lsf_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = lsf_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lsf_pkg::cmd_t       cmd,
  output lsf_pkg::stat_t      stat,
  input  logic signed [31:0]  x_value,
  input  logic signed [31:0]  y_value,
  output logic                done,
  output logic signed [47:0]  intercept,
  output logic signed [47:0]  slope,
  output logic [62:0]         regression_sum_squares,
  output logic [62:0]         residual_sum_squares,
  output logic [62:0]         residual_variance,
  output logic [1:0]          fit_status
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = 32 + AW;

  logic [31:0]      x_mem [MAX_POINTS];
  logic [31:0]      y_mem [MAX_POINTS];
  logic [31:0]      rd_x, rd_y, xm, ym;
  logic [CW-1:0]    count, nm2;
  logic [AW-1:0]    idx;
  logic             ovf_seen;
  logic [SUM_W-1:0] sum_x, sum_y, mag_sx, mag_sy;
  logic [63:0]      lxx, lxy, mag_lxy, fit, nfit;
  logic [47:0]      b, a;
  logic [62:0]      u, q, var_r;
  logic [63:0]      dx, dy, du, dr, xm64, ym64;
  logic [63:0]      mul_a, mul_b, mul_prod, div_mean;
  logic [127:0]     div_num, div_quo;
  logic [63:0]      div_den;
  logic             mul_done, div_done;

  assign xm64    = {{32{xm[31]}}, xm};
  assign ym64    = {{32{ym[31]}}, ym};
  assign dx      = {{32{rd_x[31]}}, rd_x} - xm64;
  assign dy      = {{32{rd_y[31]}}, rd_y} - ym64;
  assign du      = lsf_pkg::sadd64(fit, 64'(-ym64));
  assign nfit    = (fit == lsf_pkg::S64_MIN) ? lsf_pkg::S64_MAX : 64'(-fit);
  assign dr      = lsf_pkg::sadd64({{32{rd_y[31]}}, rd_y}, nfit);
  assign mag_sx  = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : sum_x;
  assign mag_sy  = sum_y[SUM_W-1] ? SUM_W'(-sum_y) : sum_y;
  assign mag_lxy = lxy[63] ? 64'(-lxy) : lxy;
  assign nm2     = count - CW'(2);
  assign div_mean = div_quo[63:0];

  always_comb begin
    mul_a = dx;
    mul_b = dx;
    unique case (cmd.mul_sel)
      lsf_pkg::MUL_DXDX: begin mul_a = dx; mul_b = dx; end
      lsf_pkg::MUL_DXDY: begin mul_a = dx; mul_b = dy; end
      lsf_pkg::MUL_BXM:  begin mul_a = {{16{b[47]}}, b}; mul_b = xm64; end
      lsf_pkg::MUL_BX:   begin mul_a = {{16{b[47]}}, b}; mul_b = {{32{rd_x[31]}}, rd_x}; end
      lsf_pkg::MUL_DUDU: begin mul_a = du; mul_b = du; end
      lsf_pkg::MUL_DRDR: begin mul_a = dr; mul_b = dr; end
      default:           begin mul_a = dx; mul_b = dx; end
    endcase
  end

  always_comb begin
    unique case (cmd.div_sel)
      lsf_pkg::DIV_MEAN_X: begin
        div_num = 128'(mag_sx) + 128'(count >> 1);
        div_den = 64'(count);
      end
      lsf_pkg::DIV_MEAN_Y: begin
        div_num = 128'(mag_sy) + 128'(count >> 1);
        div_den = 64'(count);
      end
      lsf_pkg::DIV_SLOPE: begin
        div_num = (128'(mag_lxy) << FRAC_BITS) + 128'(lxx >> 1);
        div_den = lxx;
      end
      default: begin
        div_num = 128'(q) + 128'(nm2 >> 1);
        div_den = 64'(nm2);
      end
    endcase
  end

  lsf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.mul_go),
    .op_a (mul_a),
    .op_b (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  lsf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign stat.div_done = div_done;
  assign stat.mul_done = mul_done;
  assign stat.idx_last = (CW'(idx) == (count - CW'(1)));
  assign stat.lxx_zero = (lxx == 64'd0);
  assign stat.n_ge3    = (count >= CW'(3));

  always_ff @(posedge clk) begin
    if (cmd.load && (count < CW'(MAX_POINTS))) begin
      x_mem[count[AW-1:0]] <= x_value;
      y_mem[count[AW-1:0]] <= y_value;
    end
    rd_x <= x_mem[idx];
    rd_y <= y_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
      sum_x    <= '0;
      sum_y    <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        if (count < CW'(MAX_POINTS)) begin
          count <= count + CW'(1);
          sum_x <= sum_x + {{AW{x_value[31]}}, x_value};
          sum_y <= sum_y + {{AW{y_value[31]}}, y_value};
        end else begin
          ovf_seen <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count    <= '0;
        ovf_seen <= 1'b0;
        sum_x    <= '0;
        sum_y    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      lxx   <= 64'd0;
      lxy   <= 64'd0;
      u     <= 63'd0;
      q     <= 63'd0;
      var_r <= 63'd0;
      idx   <= '0;
    end
    if (cmd.idx_clr) idx <= '0;
    if (cmd.idx_inc) idx <= idx + AW'(1);
    if (cmd.ld_xm) xm <= sum_x[SUM_W-1] ? 32'(-div_mean[31:0]) : div_mean[31:0];
    if (cmd.ld_ym) ym <= sum_y[SUM_W-1] ? 32'(-div_mean[31:0]) : div_mean[31:0];
    if (cmd.ld_lxx) lxx <= lxx + mul_prod;
    if (cmd.ld_lxy) lxy <= lxy + mul_prod;
    if (cmd.ld_b) begin
      b <= lsf_pkg::clamp48(lsf_pkg::sat_mag(div_quo[63:0], lxy[63], |div_quo[127:64]));
    end
    if (cmd.ld_a) a <= lsf_pkg::clamp48(lsf_pkg::sadd64(ym64, 64'(-mul_prod)));
    if (cmd.ld_fit) fit <= lsf_pkg::sadd64({{16{a[47]}}, a}, mul_prod);
    if (cmd.ld_u) u <= lsf_pkg::uadd63(u, mul_prod[62:0]);
    if (cmd.ld_q) q <= lsf_pkg::uadd63(q, mul_prod[62:0]);
    if (cmd.ld_var) var_r <= div_quo[62:0];
    if (cmd.finish) begin
      if (lxx == 64'd0) begin
        intercept              <= '0;
        slope                  <= '0;
        regression_sum_squares <= '0;
        residual_sum_squares   <= '0;
        residual_variance      <= '0;
        fit_status             <= lsf_pkg::ST_FLAT;
      end else begin
        intercept              <= a;
        slope                  <= b;
        regression_sum_squares <= u;
        residual_sum_squares   <= q;
        residual_variance      <= var_r;
        priority if (ovf_seen)            fit_status <= lsf_pkg::ST_DROP;
        else if (count < CW'(3))          fit_status <= lsf_pkg::ST_FEW;
        else                              fit_status <= lsf_pkg::ST_OK;
      end
    end
  end

endmodule

// File: rtl/lsf_ctrl.sv
// ----------------------------------------------------------------------------
// lsf_ctrl
// Sequencer for loading, the two passes over the store and the divides.
// ----------------------------------------------------------------------------
module lsf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           last_point,
  output logic           busy,
  output lsf_pkg::cmd_t  cmd,
  input  lsf_pkg::stat_t stat
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MX_GO  = 5'd1;
  localparam logic [4:0] S_MX_W   = 5'd2;
  localparam logic [4:0] S_MY_GO  = 5'd3;
  localparam logic [4:0] S_MY_W   = 5'd4;
  localparam logic [4:0] S_P1_RD  = 5'd5;
  localparam logic [4:0] S_XX_GO  = 5'd6;
  localparam logic [4:0] S_XX_W   = 5'd7;
  localparam logic [4:0] S_XY_GO  = 5'd8;
  localparam logic [4:0] S_XY_W   = 5'd9;
  localparam logic [4:0] S_CHECK  = 5'd10;
  localparam logic [4:0] S_SL_GO  = 5'd11;
  localparam logic [4:0] S_SL_W   = 5'd12;
  localparam logic [4:0] S_AB_GO  = 5'd13;
  localparam logic [4:0] S_AB_W   = 5'd14;
  localparam logic [4:0] S_P2_RD  = 5'd15;
  localparam logic [4:0] S_FIT_GO = 5'd16;
  localparam logic [4:0] S_FIT_W  = 5'd17;
  localparam logic [4:0] S_U_GO   = 5'd18;
  localparam logic [4:0] S_U_W    = 5'd19;
  localparam logic [4:0] S_Q_GO   = 5'd20;
  localparam logic [4:0] S_Q_W    = 5'd21;
  localparam logic [4:0] S_VAR    = 5'd22;
  localparam logic [4:0] S_VAR_W  = 5'd23;
  localparam logic [4:0] S_FINISH = 5'd24;

  logic [4:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start && last_point) state_next = S_MX_GO;
      end
      S_MX_GO: begin
        cmd.clr_acc = 1'b1;
        cmd.div_go  = 1'b1;
        cmd.div_sel = lsf_pkg::DIV_MEAN_X;
        state_next  = S_MX_W;
      end
      S_MX_W: begin
        cmd.ld_xm = stat.div_done;
        if (stat.div_done) state_next = S_MY_GO;
      end
      S_MY_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = lsf_pkg::DIV_MEAN_Y;
        state_next  = S_MY_W;
      end
      S_MY_W: begin
        cmd.ld_ym = stat.div_done;
        if (stat.div_done) state_next = S_P1_RD;
      end
      S_P1_RD: state_next = S_XX_GO;
      S_XX_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = lsf_pkg::MUL_DXDX;
        state_next  = S_XX_W;
      end
      S_XX_W: begin
        cmd.ld_lxx = stat.mul_done;
        if (stat.mul_done) state_next = S_XY_GO;
      end
      S_XY_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = lsf_pkg::MUL_DXDY;
        state_next  = S_XY_W;
      end
      S_XY_W: begin
        cmd.ld_lxy = stat.mul_done;
        if (stat.mul_done) begin
          cmd.idx_inc = !stat.idx_last;
          state_next  = stat.idx_last ? S_CHECK : S_P1_RD;
        end
      end
      S_CHECK: state_next = stat.lxx_zero ? S_FINISH : S_SL_GO;
      S_SL_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = lsf_pkg::DIV_SLOPE;
        state_next  = S_SL_W;
      end
      S_SL_W: begin
        cmd.ld_b = stat.div_done;
        if (stat.div_done) state_next = S_AB_GO;
      end
      S_AB_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = lsf_pkg::MUL_BXM;
        cmd.idx_clr = 1'b1;
        state_next  = S_AB_W;
      end
      S_AB_W: begin
        cmd.ld_a = stat.mul_done;
        if (stat.mul_done) state_next = S_P2_RD;
      end
      S_P2_RD: state_next = S_FIT_GO;
      S_FIT_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = lsf_pkg::MUL_BX;
        state_next  = S_FIT_W;
      end
      S_FIT_W: begin
        cmd.ld_fit = stat.mul_done;
        if (stat.mul_done) state_next = S_U_GO;
      end
      S_U_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = lsf_pkg::MUL_DUDU;
        state_next  = S_U_W;
      end
      S_U_W: begin
        cmd.ld_u = stat.mul_done;
        if (stat.mul_done) state_next = S_Q_GO;
      end
      S_Q_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = lsf_pkg::MUL_DRDR;
        state_next  = S_Q_W;
      end
      S_Q_W: begin
        cmd.ld_q = stat.mul_done;
        if (stat.mul_done) begin
          cmd.idx_inc = !stat.idx_last;
          state_next  = stat.idx_last ? S_VAR : S_P2_RD;
        end
      end
      S_VAR: begin
        cmd.div_go  = stat.n_ge3;
        cmd.div_sel = lsf_pkg::DIV_VAR;
        state_next  = stat.n_ge3 ? S_VAR_W : S_FINISH;
      end
      S_VAR_W: begin
        cmd.ld_var = stat.div_done;
        if (stat.div_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/least_squares_line_fit.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit
// Straight-line least-squares fit over a set of loaded (x, y) points.
// ----------------------------------------------------------------------------
// channel   signals                                  transfer
// point     start, x_value, y_value, last_point      start high, busy low
// result    done, intercept, slope, *_sum_squares,   done high, one cycle
//           residual_variance, fit_status
//
// A point loads when start is high and busy low; busy stays low between the
// points of a set. The last point starts the fit, which runs up to four
// divides on the shared bit-serial divider and five products per point, over
// two passes across the store, on the shared multiplier.
// Reset clears the point count and sums; no clearing pass over the store.
// The result is presented for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module least_squares_line_fit #(
  parameter int MAX_POINTS = lsf_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = lsf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  input  logic               last_point,
  output logic               done,
  output logic signed [47:0] intercept,
  output logic signed [47:0] slope,
  output logic [62:0]        regression_sum_squares,
  output logic [62:0]        residual_sum_squares,
  output logic [62:0]        residual_variance,
  output logic [1:0]         fit_status
);

  lsf_pkg::cmd_t  cmd;
  lsf_pkg::stat_t stat;

  lsf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_point (last_point),
    .busy       (busy),
    .cmd        (cmd),
    .stat       (stat)
  );

  lsf_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .stat                   (stat),
    .x_value                (x_value),
    .y_value                (y_value),
    .done                   (done),
    .intercept              (intercept),
    .slope                  (slope),
    .regression_sum_squares (regression_sum_squares),
    .residual_sum_squares   (residual_sum_squares),
    .residual_variance      (residual_variance),
    .fit_status             (fit_status)
  );

`ifndef SYNTH
  a_last_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_point |=> busy)
    else $error("fit did not start after last point");

  a_done_after_fit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe outside end of fit");

  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    done && (fit_status == lsf_pkg::ST_FLAT) |-> (slope == '0) && (intercept == '0))
    else $error("degenerate fit with nonzero coefficients");

  a_var_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> residual_variance <= residual_sum_squares)
    else $error("residual variance above residual sum");
`endif

endmodule

// File: dv/tb_least_squares_line_fit.sv
// ----------------------------------------------------------------------------
// tb_least_squares_line_fit
// Self-checking bench for the line-fit block. A short table of directed sets
// walks extremes, flat x, short sets and an exact line. Random sets follow:
// small and long sets, flat sets, noisy lines, extremes and store overflow.
// Each result is compared field by field against an in-bench predictor, or a
// fixed flat one, under phases of sender idling and a pause for all results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_least_squares_line_fit;

  localparam int NPTS        = lsf_pkg::MAX_POINTS_DEF;
  localparam int FB          = lsf_pkg::FRAC_BITS_DEF;
  localparam int ITEM_TARGET = 1900;
  localparam int CYCLE_LIMIT = 3000000;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic signed [47:0] intercept;
    logic signed [47:0] slope;
    logic [62:0]        u_sum;
    logic [62:0]        q_sum;
    logic [62:0]        variance;
    logic [1:0]         status;
  } fit_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
    bit          typed;
    fit_t        fixed;
  } row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic               last_point;
  logic               done;
  logic signed [47:0] intercept;
  logic signed [47:0] slope;
  logic [62:0]        regression_sum_squares;
  logic [62:0]        residual_sum_squares;
  logic [62:0]        residual_variance;
  logic [1:0]         fit_status;

  least_squares_line_fit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_value(x_value), .y_value(y_value), .last_point(last_point),
    .done(done), .intercept(intercept), .slope(slope),
    .regression_sum_squares(regression_sum_squares),
    .residual_sum_squares(residual_sum_squares),
    .residual_variance(residual_variance), .fit_status(fit_status)
  );

  fit_t   pending_fits[$];
  row_t   rows[$];
  int     errors;
  int     cycles;
  int     idle_pct;
  int     items;

  longint pts_x[NPTS];
  longint pts_y[NPTS];
  int     pts_n;
  bit     pts_dropped;
  longint acc_x;
  longint acc_y;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] mag(longint v);
    logic [63:0] u;
    u = v;
    return v < 0 ? ~u + 64'd1 : u;
  endfunction

  function automatic longint from_mag(logic [63:0] m, bit neg, bit ovf);
    if (neg) begin
      if (ovf || m[63]) return I64_MIN;
      return -longint'(m);
    end
    if (ovf || m[63]) return I64_MAX;
    return longint'(m);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(I64_MAX)) return I64_MAX;
    if (s < 65'(I64_MIN)) return I64_MIN;
    return longint'(s);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    p = p + (128'd1 << (FB - 1));
    p = p >> FB;
    return from_mag(p[63:0], (a < 0) != (b < 0), p[127:64] != 0);
  endfunction

  function automatic longint fx_div(longint num, longint den);
    logic [127:0] p, d, q;
    d = {64'd0, den};
    p = ({64'd0, mag(num)} << FB) + (d >> 1);
    q = p / d;
    return from_mag(q[63:0], num < 0, q[127:64] != 0);
  endfunction

  function automatic longint mean(longint s, int n);
    logic [63:0] m;
    m = (mag(s) + 64'(n / 2)) / 64'(n);
    return s < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip48(longint v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return v;
  endfunction

  function automatic logic [63:0] usat63(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return s[63] ? 64'h7FFF_FFFF_FFFF_FFFF : s;
  endfunction

  // load one point; return 1 with the fit when it closes the set
  function automatic bit line_fit_step(logic [31:0] xv, logic [31:0] yv, logic lst,
                                       output fit_t r);
    longint xm, ym, lxx, lxy, b, a, dx, fit, du, dr;
    logic [63:0] u, q, v;
    int n;
    r = '{default: '0};
    if (pts_n < NPTS) begin
      pts_x[pts_n] = longint'(signed'(xv));
      pts_y[pts_n] = longint'(signed'(yv));
      acc_x += pts_x[pts_n];
      acc_y += pts_y[pts_n];
      pts_n++;
    end else begin
      pts_dropped = 1'b1;
    end
    if (!lst) return 1'b0;
    n = pts_n;
    xm = mean(acc_x, n);
    ym = mean(acc_y, n);
    lxx = 0;
    lxy = 0;
    for (int i = 0; i < n; i++) begin
      dx = pts_x[i] - xm;
      lxx += fx_mul(dx, dx);
      lxy += fx_mul(dx, pts_y[i] - ym);
    end
    if (lxx == 0) begin
      r.status = lsf_pkg::ST_FLAT;
    end else begin
      u = 0;
      q = 0;
      v = 0;
      b = clip48(fx_div(lxy, lxx));
      a = clip48(sat_add(ym, -fx_mul(b, xm)));
      for (int i = 0; i < n; i++) begin
        fit = sat_add(a, fx_mul(b, pts_x[i]));
        du = sat_add(fit, -ym);
        dr = sat_add(pts_y[i], fit == I64_MIN ? I64_MAX : -fit);
        u = usat63(u, fx_mul(du, du));
        q = usat63(q, fx_mul(dr, dr));
      end
      if (n >= 3) v = (q + 64'((n - 2) / 2)) / 64'(n - 2);
      r.intercept = a[47:0];
      r.slope = b[47:0];
      r.u_sum = u[62:0];
      r.q_sum = q[62:0];
      r.variance = v[62:0];
      r.status = pts_dropped ? lsf_pkg::ST_DROP :
                 (n < 3 ? lsf_pkg::ST_FEW : lsf_pkg::ST_OK);
    end
    pts_n = 0;
    pts_dropped = 1'b0;
    acc_x = 0;
    acc_y = 0;
    return 1'b1;
  endfunction

  task automatic send_point(logic [31:0] xv, logic [31:0] yv, logic lst, bit typed,
                            fit_t fixed);
    fit_t r;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    x_value <= xv;
    y_value <= yv;
    last_point <= lst;
    while (busy) @(negedge clk);
    @(posedge clk);
    if (line_fit_step(xv, yv, lst, r)) pending_fits.push_back(typed ? fixed : r);
    items++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(int mode, int i, longint base, longint step);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097151)) - 1048576);
      2: return 32'(base + step * i + $signed($urandom_range(255)) - 128);
      default: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic add_row(logic [31:0] xv, logic [31:0] yv, logic lst, bit typed);
    row_t rw;
    rw.x = xv;
    rw.y = yv;
    rw.last = lst;
    rw.typed = typed;
    rw.fixed = '{default: '0};
    rw.fixed.status = lsf_pkg::ST_FLAT;
    rows.push_back(rw);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    fit_t e;
    if (!rst && done) begin
      if (pending_fits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected fit result, status %0d", fit_status);
      end else begin
        e = pending_fits.pop_front();
        if (intercept !== e.intercept || slope !== e.slope ||
            regression_sum_squares !== e.u_sum || residual_sum_squares !== e.q_sum ||
            residual_variance !== e.variance || fit_status !== e.status) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp a=%0d b=%0d U=%0d Q=%0d var=%0d st=%0d", e.intercept,
                     e.slope, e.u_sum, e.q_sum, e.variance, e.status);
            $display("         got a=%0d b=%0d U=%0d Q=%0d var=%0d st=%0d", intercept,
                     slope, regression_sum_squares, residual_sum_squares,
                     residual_variance, fit_status);
          end
        end
      end
    end
  end

  initial begin
    int n, mode, wait_cycles;
    longint base, step;
    bit flat;
    logic [31:0] xv, xf;
    fit_t none;
    none = '{default: '0};
    errors = 0;
    cycles = 0;
    items = 0;
    idle_pct = 0;
    pts_n = 0;
    pts_dropped = 1'b0;
    acc_x = 0;
    acc_y = 0;
    rst = 1'b1;
    start = 1'b0;
    x_value = '0;
    y_value = '0;
    last_point = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_row(32'd5, 32'd7, 1'b1, 1'b1);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_row(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
    add_row(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    add_row(32'h0, 32'h0, 1'b0, 1'b0);
    add_row(32'h1_0000, 32'h2_0000, 1'b0, 1'b0);
    add_row(32'h2_0000, 32'h4_0000, 1'b1, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_row(32'h0, 32'h0, 1'b1, 1'b0);
    add_row(32'hFFFF_FFFF, 32'h1, 1'b0, 1'b0);
    add_row(32'h1, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_row(32'h0, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_row(32'h3, 32'h8000_0000, 1'b1, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h1234_5678, 1'b0, 1'b0);
    add_row(32'h7FFF_FFFF, 32'hDEAD_BEEF, 1'b0, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].last, rows[i].typed,
                                 rows[i].fixed);
    hold_until_drained();

    while (items < ITEM_TARGET) begin
      case ((items / 200) % 4)
        0: idle_pct = 0;
        1: idle_pct = 64;
        2: idle_pct = 0;
        default: idle_pct = 24;
      endcase
      case ($urandom_range(39))
        0: n = $urandom_range(132, 129);
        1, 2: n = 1;
        3, 4, 5: n = $urandom_range(40, 12);
        default: n = $urandom_range(8, 2);
      endcase
      mode = $urandom_range(3);
      flat = ($urandom_range(9) == 0);
      base = $signed($urandom_range(65535)) - 32768;
      base = base <<< $urandom_range(12);
      step = $signed($urandom_range(4095)) <<< $urandom_range(8);
      xf = pick_value(mode, 0, base, step);
      for (int i = 0; i < n; i++) begin
        xv = flat ? xf : pick_value(mode, i, base, step);
        send_point(xv, pick_value(mode, i, base, 3 * step), i == n - 1, 1'b0, none);
      end
      if ($urandom_range(19) == 0) hold_until_drained();
    end

    hold_until_drained();
    wait_cycles = 0;
    while (wait_cycles < 7000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (errors == 0 && pending_fits.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
